FILE: hdl/bnsr_pkg.sv
// Shared widths, register indexes and pipeline payload types for the bead/node spring block.
`timescale 1ns / 1ps
package bnsr_pkg;

    localparam int POS_W      = 32;
    localparam int NRM_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SQ_STEPS   = 31;  // root bits of a 62-bit square
    localparam int DIV_STEPS  = 63;  // quotient bits of stiffness * |cutoff - r|

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS = 2'd0,
        CFG_CUTOFF    = 2'd1,
        CFG_MIN_DIST  = 2'd2
    } t_cfg_idx;

    // Per-pair data carried alongside the sqrt and divide work.
    typedef struct packed {
        logic                    hit;
        logic [2:0]              neg;   // sign of dr per axis
        logic [2:0][30:0]        mag;   // |dr| per axis (valid on a hit)
        logic [2:0][POS_W-1:0]   arm;
    } t_carry;

    typedef struct packed {
        t_carry      c;
        logic [61:0] x;     // radicand, consumed two bits per step
        logic [31:0] rem;
        logic [30:0] root;
    } t_sq;

    typedef struct packed {
        t_carry      c;
        logic        dneg;  // cutoff - r is negative
        logic [30:0] dvs;   // clamped r
        logic [30:0] rem;
        logic [62:0] numq;  // numerator out, quotient in
    } t_dv;

endpackage

FILE: hdl/bnsr_in_if.sv
// Input channel: one bead/node pair per beat.
`timescale 1ns / 1ps
interface bnsr_in_if;
    import bnsr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  bead_x;
    logic signed [POS_W-1:0]  bead_y;
    logic signed [POS_W-1:0]  bead_z;
    logic signed [POS_W-1:0]  node_x;
    logic signed [POS_W-1:0]  node_y;
    logic signed [POS_W-1:0]  node_z;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic signed [NRM_W-1:0]  normal_z;
    logic signed [POS_W-1:0]  arm_x;
    logic signed [POS_W-1:0]  arm_y;
    logic signed [POS_W-1:0]  arm_z;

    modport source (
        output valid, bead_x, bead_y, bead_z, node_x, node_y, node_z,
               normal_x, normal_y, normal_z, arm_x, arm_y, arm_z,
        input  ready
    );
    modport sink (
        input  valid, bead_x, bead_y, bead_z, node_x, node_y, node_z,
               normal_x, normal_y, normal_z, arm_x, arm_y, arm_z,
        output ready
    );
endinterface

FILE: hdl/bnsr_out_if.sv
// Output channel: hit flag, bead force and vesicle torque per beat.
`timescale 1ns / 1ps
interface bnsr_out_if;
    import bnsr_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [POS_W-1:0]  force_x;
    logic signed [POS_W-1:0]  force_y;
    logic signed [POS_W-1:0]  force_z;
    logic signed [POS_W-1:0]  torque_x;
    logic signed [POS_W-1:0]  torque_y;
    logic signed [POS_W-1:0]  torque_z;

    modport source (
        output valid, hit, force_x, force_y, force_z, torque_x, torque_y, torque_z,
        input  ready
    );
    modport sink (
        input  valid, hit, force_x, force_y, force_z, torque_x, torque_y, torque_z,
        output ready
    );
endinterface

FILE: hdl/bead_node_spring_repulsion.sv
// Top level: pipelined bead/membrane-node spring repulsion with vesicle torque.
`timescale 1ns / 1ps
// One bead/node pair enters per beat and yields exactly one result beat, in order.
// Throughput is one pair per clock while the output side takes beats. The pipe
// has 4 front stages (difference, magnitude, products, side/range test),
// 31 stages of a bit-per-stage square root, 2 stages to clamp r and form
// stiffness*|cutoff-r|, 63 stages of a bit-per-stage divider, 2 force stages,
// 1 torque product stage and the output register. The whole pipe shares one
// advance enable: it moves whenever the output register is empty or being taken,
// so a held output stalls every stage in place and input ready drops with it.
// Misses (wrong side of the normal, zero dr, outside cutoff) give hit = 0 and all
// force and torque fields zero. Registers are written through the plain write port
// and must only change while no pair is in flight. Values are fixed point with
// FRAC_BITS fraction bits; forces and torques saturate to 32-bit signed.
module bead_node_spring_repulsion #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bnsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bnsr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bnsr_in_if.sink                            i_in,
    bnsr_out_if.source                         o_out
);
    import bnsr_pkg::*;

    localparam logic [31:0] STIFF_RST  = 32'(64'(1) << FRAC_BITS);
    localparam logic [30:0] CUTOFF_RST = 31'(64'(10) << FRAC_BITS);

    // One square-root step: restoring, two radicand bits per step.
    function automatic t_sq sq_step(input t_sq s);
        t_sq         o;
        logic [33:0] t;
        logic [33:0] trial;
        o     = s;
        t     = {s.rem, s.x[61:60]};
        trial = {1'b0, s.root, 2'b01};
        o.x   = {s.x[59:0], 2'b00};
        if (t >= trial) begin
            o.rem  = 32'(t - trial);
            o.root = {s.root[29:0], 1'b1};
        end else begin
            o.rem  = t[31:0];
            o.root = {s.root[29:0], 1'b0};
        end
        return o;
    endfunction

    // One divider step: restoring, one quotient bit per step.
    function automatic t_dv dv_step(input t_dv s);
        t_dv         o;
        logic [31:0] t;
        logic        q;
        o = s;
        t = {s.rem, s.numq[62]};
        q = (t >= {1'b0, s.dvs});
        if (q) begin
            o.rem = 31'(t - {1'b0, s.dvs});
        end else begin
            o.rem = t[30:0];
        end
        o.numq = {s.numq[61:0], q};
        return o;
    endfunction

    // Saturate sign/magnitude to 32-bit signed; big means magnitude >= 2^31.
    function automatic logic [31:0] sat32(input logic neg, input logic big,
                                          input logic [30:0] low);
        logic [31:0] v;
        if (big) begin
            v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            v = neg ? (32'd0 - {1'b0, low}) : {1'b0, low};
        end
        return v;
    endfunction

    // ---------------- configuration ----------------
    logic [31:0] r_stiff;
    logic [30:0] r_cutoff;
    logic [30:0] r_min_dist;
    logic [61:0] r_cut_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff    <= STIFF_RST;
            r_cutoff   <= CUTOFF_RST;
            r_min_dist <= 31'd1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_STIFFNESS: r_stiff    <= i_cfg_data;
                CFG_CUTOFF:    r_cutoff   <= i_cfg_data[30:0];
                CFG_MIN_DIST:  r_min_dist <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // cutoff^2 is registered and follows the register in the next cycle; pairs reach the test much later
    always_ff @(posedge i_clk) begin
        r_cut_sq <= 62'(r_cutoff) * 62'(r_cutoff);
    end

    // ---------------- pipe control ----------------
    logic r_o_v;
    logic w_adv;

    assign w_adv      = !r_o_v || o_out.ready;
    assign i_in.ready = w_adv;

    // ---------------- stage 0: dr = bead - node ----------------
    logic signed [31:0] w_bead [3];
    logic signed [31:0] w_node [3];
    logic signed [17:0] w_nrm  [3];
    logic        [31:0] w_arm  [3];

    assign w_bead = '{i_in.bead_x, i_in.bead_y, i_in.bead_z};
    assign w_node = '{i_in.node_x, i_in.node_y, i_in.node_z};
    assign w_nrm  = '{i_in.normal_x, i_in.normal_y, i_in.normal_z};
    assign w_arm  = '{i_in.arm_x, i_in.arm_y, i_in.arm_z};

    logic               r0_v;
    logic signed [32:0] r0_dr  [3];
    logic signed [17:0] r0_nrm [3];
    logic        [31:0] r0_arm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_adv) begin
            r0_v <= i_in.valid;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r0_dr[i]  <= 33'(w_bead[i]) - 33'(w_node[i]);
                r0_nrm[i] <= w_nrm[i];
                r0_arm[i] <= w_arm[i];
            end
        end
    end

    // ---------------- stage 1: |dr| ----------------
    logic               r1_v;
    logic signed [32:0] r1_dr  [3];
    logic        [32:0] r1_mag [3];
    logic signed [17:0] r1_nrm [3];
    logic        [31:0] r1_arm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= r0_v;
        end
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_dr[i]  <= r0_dr[i];
                r1_mag[i] <= r0_dr[i][32] ? 33'(-r0_dr[i]) : 33'(r0_dr[i]);
                r1_nrm[i] <= r0_nrm[i];
                r1_arm[i] <= r0_arm[i];
            end
        end
    end

    // ---------------- stage 2: dot and square terms ----------------
    logic               r2_v;
    logic signed [50:0] r2_dot [3];
    logic        [61:0] r2_sq  [3];
    logic               r2_far;
    t_carry             r2_c;
    logic               n2_far;

    always_comb begin
        n2_far = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r1_mag[i] >= {2'b00, r_cutoff}) begin
                n2_far = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
        if (w_adv) begin
            r2_far   <= n2_far;
            r2_c.hit <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r2_dot[i]     <= r1_dr[i] * r1_nrm[i];
                // only the low 31 bits matter: a pair with larger |dr| misses
                r2_sq[i]      <= 62'(r1_mag[i][30:0]) * 62'(r1_mag[i][30:0]);
                r2_c.neg[i]   <= r1_dr[i][32];
                r2_c.mag[i]   <= r1_mag[i][30:0];
                r2_c.arm[i]   <= r1_arm[i];
            end
        end
    end

    // ---------------- stage 3: side and range test ----------------
    logic signed [52:0] n3_dot;
    logic        [63:0] n3_r2;
    logic               n3_hit;
    t_carry             n3_c;
    t_sq                r_sq   [SQ_STEPS+1];
    logic               r_sq_v [SQ_STEPS+1];

    always_comb begin
        n3_dot = 53'(r2_dot[0]) + 53'(r2_dot[1]) + 53'(r2_dot[2]);
        n3_r2  = 64'(r2_sq[0]) + 64'(r2_sq[1]) + 64'(r2_sq[2]);
        n3_hit = !r2_far && !n3_dot[52] && (n3_dot != '0) && (n3_r2 < {2'b00, r_cut_sq});
        n3_c     = r2_c;
        n3_c.hit = n3_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_v[0] <= r2_v;
        end
        if (w_adv) begin
            r_sq[0].c     <= n3_c;
            r_sq[0].x     <= n3_r2[61:0];
            r_sq[0].rem   <= '0;
            r_sq[0].root  <= '0;
        end
    end

    // ---------------- square root pipe ----------------
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            if (w_adv) begin
                r_sq[k+1] <= sq_step(r_sq[k]);
            end
        end
    end

    // ---------------- clamp r, cutoff - r ----------------
    logic               r_m_v;
    t_carry             r_m_c;
    logic               r_m_dneg;
    logic        [30:0] r_m_dvs;
    logic        [30:0] r_m_dmag;
    logic        [30:0] n_m_md;
    logic        [30:0] n_m_r;
    logic signed [31:0] n_m_d;

    always_comb begin
        n_m_md = (r_min_dist == '0) ? 31'd1 : r_min_dist;
        n_m_r  = (r_sq[SQ_STEPS].root < n_m_md) ? n_m_md : r_sq[SQ_STEPS].root;
        n_m_d  = $signed({1'b0, r_cutoff}) - $signed({1'b0, n_m_r});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (w_adv) begin
            r_m_v <= r_sq_v[SQ_STEPS];
        end
        if (w_adv) begin
            r_m_c    <= r_sq[SQ_STEPS].c;
            r_m_dneg <= n_m_d[31];
            r_m_dvs  <= n_m_r;
            r_m_dmag <= n_m_d[31] ? 31'(-n_m_d) : n_m_d[30:0];
        end
    end

    // ---------------- numerator, then divider pipe ----------------
    t_dv  r_dv   [DIV_STEPS+1];
    logic r_dv_v [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_v[0] <= r_m_v;
        end
        if (w_adv) begin
            r_dv[0].c    <= r_m_c;
            r_dv[0].dneg <= r_m_dneg;
            r_dv[0].dvs  <= r_m_dvs;
            r_dv[0].rem  <= '0;
            r_dv[0].numq <= 63'(r_stiff) * 63'(r_m_dmag);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            if (w_adv) begin
                r_dv[k+1] <= dv_step(r_dv[k]);
            end
        end
    end

    // ---------------- force: |dr| * g split in two partial products ----------------
    logic        r_f1_v;
    t_carry      r_f1_c;
    logic        r_f1_dneg;
    logic [62:0] r_f1_pl [3];
    logic [61:0] r_f1_ph [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (w_adv) begin
            r_f1_v <= r_dv_v[DIV_STEPS];
        end
        if (w_adv) begin
            r_f1_c    <= r_dv[DIV_STEPS].c;
            r_f1_dneg <= r_dv[DIV_STEPS].dneg;
            for (int i = 0; i < 3; i++) begin
                r_f1_pl[i] <= 63'(r_dv[DIV_STEPS].c.mag[i])
                            * 63'(r_dv[DIV_STEPS].numq[31:0]);
                r_f1_ph[i] <= 62'(r_dv[DIV_STEPS].c.mag[i])
                            * 62'(r_dv[DIV_STEPS].numq[62:32]);
            end
        end
    end

    logic        r_f2_v;
    t_carry      r_f2_c;
    logic [31:0] r_f2_f [3];
    logic [94:0] n_f2_sum [3];
    logic [94:0] n_f2_sh  [3];
    logic [31:0] n_f2_f   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f2_sum[i] = 95'({r_f1_ph[i], 32'd0}) + 95'(r_f1_pl[i]);
            n_f2_sh[i]  = n_f2_sum[i] >> FRAC_BITS;
            n_f2_f[i]   = sat32(r_f1_c.neg[i] ^ r_f1_dneg, |n_f2_sh[i][94:31],
                                n_f2_sh[i][30:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (w_adv) begin
            r_f2_v <= r_f1_v;
        end
        if (w_adv) begin
            r_f2_c <= r_f1_c;
            r_f2_f <= n_f2_f;
        end
    end

    // ---------------- torque = force x arm ----------------
    logic               r_t1_v;
    logic               r_t1_hit;
    logic        [31:0] r_t1_f [3];
    logic signed [63:0] r_t1_p [6];
    logic signed [31:0] w_fs   [3];
    logic signed [31:0] w_as   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fs[i] = $signed(r_f2_f[i]);
            w_as[i] = $signed(r_f2_c.arm[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
        end else if (w_adv) begin
            r_t1_v <= r_f2_v;
        end
        if (w_adv) begin
            r_t1_hit  <= r_f2_c.hit;
            r_t1_f    <= r_f2_f;
            r_t1_p[0] <= w_fs[1] * w_as[2];
            r_t1_p[1] <= w_fs[2] * w_as[1];
            r_t1_p[2] <= w_fs[2] * w_as[0];
            r_t1_p[3] <= w_fs[0] * w_as[2];
            r_t1_p[4] <= w_fs[0] * w_as[1];
            r_t1_p[5] <= w_fs[1] * w_as[0];
        end
    end

    // ---------------- output register ----------------
    logic               r_o_hit;
    logic        [31:0] r_o_f [3];
    logic        [31:0] r_o_t [3];
    logic signed [64:0] n_o_diff [3];
    logic        [63:0] n_o_mag  [3];
    logic        [63:0] n_o_sh   [3];
    logic        [31:0] n_o_t    [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_o_diff[k] = 65'(r_t1_p[2*k]) - 65'(r_t1_p[2*k+1]);
            n_o_mag[k]  = n_o_diff[k][64] ? 64'(-n_o_diff[k]) : n_o_diff[k][63:0];
            n_o_sh[k]   = n_o_mag[k] >> FRAC_BITS;
            n_o_t[k]    = sat32(n_o_diff[k][64], |n_o_sh[k][63:31], n_o_sh[k][30:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_adv) begin
            r_o_v <= r_t1_v;
        end
        if (w_adv) begin
            r_o_hit <= r_t1_hit;
            for (int k = 0; k < 3; k++) begin
                r_o_f[k] <= r_t1_hit ? r_t1_f[k] : 32'd0;
                r_o_t[k] <= r_t1_hit ? n_o_t[k]  : 32'd0;
            end
        end
    end

    assign o_out.valid    = r_o_v;
    assign o_out.hit      = r_o_hit;
    assign o_out.force_x  = r_o_f[0];
    assign o_out.force_y  = r_o_f[1];
    assign o_out.force_z  = r_o_f[2];
    assign o_out.torque_x = r_o_t[0];
    assign o_out.torque_y = r_o_t[1];
    assign o_out.torque_z = r_o_t[2];

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && !r_o_hit) |-> (r_o_f[0] == '0 && r_o_f[1] == '0 && r_o_f[2] == '0
            && r_o_t[0] == '0 && r_o_t[1] == '0 && r_o_t[2] == '0))
        else $error("miss result carries nonzero force or torque");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[DIV_STEPS] |-> (r_dv[DIV_STEPS].rem < r_dv[DIV_STEPS].dvs))
        else $error("divider remainder not below divisor");

    a_dvs_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_v |-> (r_m_dvs != '0))
        else $error("clamped distance is zero");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_o_v)
        else $error("output valid right after reset");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the bead/node spring repulsion block.
`timescale 1ns / 1ps
module tb_top;
    import bnsr_pkg::*;

    // Index 3 selects no register and must be dropped by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 4000;
    localparam int RAND_PER_SET = 215;
    localparam int FRAC_W       = 16;

    typedef struct {
        logic signed [31:0] bead [3];
        logic signed [31:0] node [3];
        logic signed [17:0] nrm  [3];
        logic signed [31:0] arm  [3];
    } t_pair;

    typedef struct {
        logic               hit;
        logic signed [31:0] frc [3];
        logic signed [31:0] trq [3];
    } t_res;

    typedef struct {
        t_pair p;
        bit    typed;
        t_res  e;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bnsr_in_if  in_ch ();
    bnsr_out_if out_ch ();

    bead_node_spring_repulsion dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // Bench copy of the registers, updated with the same masking as the block.
    logic [31:0] stiff_q;
    logic [30:0] cut_q;
    logic [30:0] mind_q;

    t_res force_q [$];      // expected result beats, oldest first
    t_pair cur_pair;        // beat being offered on the input channel
    bit    cur_typed;
    t_res  cur_exp;
    int    err_cnt;
    int    pairs_in;
    int    beats_out;
    int    hits_out;
    int    idle_cnt;

    // floor square root, one result bit per pass
    function automatic logic [31:0] root_floor(logic [63:0] x);
        logic [63:0] rem;
        logic [31:0] res;
        logic [63:0] trial;
        rem = x;
        res = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = ({32'd0, res} << (b + 1)) + (64'd1 << (2 * b));
            if (rem >= trial) begin
                rem = rem - trial;
                res[b] = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] sat_word(bit neg, logic [63:0] mag);
        if (neg) begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic [31:0] cross_term(logic signed [31:0] a, logic signed [31:0] b,
                                               logic signed [31:0] c, logic signed [31:0] d);
        logic signed [65:0] x;
        logic [65:0] mag;
        x = 66'(a) * 66'(b) - 66'(c) * 66'(d);
        mag = x[65] ? -x : x;
        mag = mag >> FRAC_W;
        return sat_word(x[65], (mag > 66'hFFFF_FFFF) ? 64'h1_0000_0000 : mag[63:0]);
    endfunction

    function automatic t_res spring_force(t_pair p);
        t_res o;
        logic signed [33:0] dr [3];
        logic [32:0] m [3];
        longint dot;
        bit hit;
        logic [69:0] r2;
        logic [31:0] r;
        logic [31:0] md;
        logic signed [33:0] d;
        bit dneg;
        logic [63:0] g;
        logic [127:0] prod;
        logic [63:0] fmag;
        o.hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            o.frc[i] = '0;
            o.trq[i] = '0;
        end
        hit = 1'b1;
        dot = 0;
        r2 = '0;
        for (int i = 0; i < 3; i++) begin
            dr[i] = 34'(p.bead[i]) - 34'(p.node[i]);
            m[i] = dr[i][33] ? 33'(-dr[i]) : 33'(dr[i]);
            dot += longint'(dr[i]) * longint'(p.nrm[i]);
            if (m[i] >= {2'b0, cut_q}) hit = 1'b0;
        end
        if (dot <= 0) hit = 1'b0;
        if (!hit) return o;
        for (int i = 0; i < 3; i++) r2 += 70'(m[i]) * 70'(m[i]);
        if (r2 >= 70'(cut_q) * 70'(cut_q)) return o;
        r = root_floor(r2[63:0]);
        md = (mind_q == 0) ? 32'd1 : {1'b0, mind_q};
        if (r < md) r = md;
        d = 34'(cut_q) - 34'(r);
        dneg = d[33];
        g = (64'(stiff_q) * 64'(dneg ? -d : d)) / 64'(r);
        o.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            prod = (128'(m[i]) * 128'(g)) >> FRAC_W;
            fmag = (prod > 128'h1_0000_0000) ? 64'h1_0000_0000 : prod[63:0];
            o.frc[i] = sat_word(dr[i][33] != dneg, fmag);
        end
        o.trq[0] = cross_term(o.frc[1], p.arm[2], o.frc[2], p.arm[1]);
        o.trq[1] = cross_term(o.frc[2], p.arm[0], o.frc[0], p.arm[2]);
        o.trq[2] = cross_term(o.frc[0], p.arm[1], o.frc[1], p.arm[0]);
        return o;
    endfunction

    task automatic put_pair(t_pair p);
        in_ch.bead_x = p.bead[0]; in_ch.bead_y = p.bead[1]; in_ch.bead_z = p.bead[2];
        in_ch.node_x = p.node[0]; in_ch.node_y = p.node[1]; in_ch.node_z = p.node[2];
        in_ch.normal_x = p.nrm[0]; in_ch.normal_y = p.nrm[1]; in_ch.normal_z = p.nrm[2];
        in_ch.arm_x = p.arm[0]; in_ch.arm_y = p.arm[1]; in_ch.arm_z = p.arm[2];
    endtask

    // Input monitor: every accepted pair queues its expected beat.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            force_q.push_back(cur_typed ? cur_exp : spring_force(cur_pair));
            pairs_in++;
        end
    end

    task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            err_cnt++;
        end
    endtask

    // Output checker against the oldest expectation.
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_out++;
            if (out_ch.hit === 1'b1) hits_out++;
            if (force_q.size() == 0) begin
                $error("result beat with nothing expected");
                err_cnt++;
            end else begin
                e = force_q.pop_front();
                cmp_field("hit", 32'(e.hit), 32'(out_ch.hit));
                cmp_field("force_x", e.frc[0], out_ch.force_x);
                cmp_field("force_y", e.frc[1], out_ch.force_y);
                cmp_field("force_z", e.frc[2], out_ch.force_z);
                cmp_field("torque_x", e.trq[0], out_ch.torque_x);
                cmp_field("torque_y", e.trq[1], out_ch.torque_y);
                cmp_field("torque_z", e.trq[2], out_ch.torque_z);
            end
        end
    end

    // Receiver: duty-cycle stall pattern whose period and duty are re-drawn at random,
    // with some stretches of no back-pressure at all.
    int rx_period, rx_duty, rx_phase, rx_left;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_left = $urandom_range(50, 300);
            rx_period = $urandom_range(1, 9);
            rx_duty = ($urandom_range(0, 3) == 0) ? rx_period : $urandom_range(1, rx_period);
            rx_phase = 0;
        end
        rx_left--;
        out_ch.ready = (rx_phase < rx_duty);
        rx_phase = (rx_phase + 1 >= rx_period) ? 0 : rx_phase + 1;
    end

    // Watchdog: no beat moved for too long while work is pending.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cnt = 0;
        end else if (in_ch.valid || force_q.size() != 0) begin
            idle_cnt++;
            if (idle_cnt >= STALL_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    int burst_left;

    // Drive one pair; bursts of random length separated by random gaps.
    task automatic send_pair(t_pair p, bit typed, t_res e);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        cur_pair = p;
        cur_typed = typed;
        cur_exp = e;
        put_pair(p);
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (force_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_STIFFNESS: stiff_q = val;
            CFG_CUTOFF:    cut_q = val[30:0];
            CFG_MIN_DIST:  mind_q = val[30:0];
            default: ;
        endcase
    endtask

    function automatic t_pair blank_pair();
        t_pair p;
        for (int i = 0; i < 3; i++) begin
            p.bead[i] = '0; p.node[i] = '0; p.nrm[i] = '0; p.arm[i] = '0;
        end
        return p;
    endfunction

    function automatic t_res miss_res();
        t_res e;
        e.hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            e.frc[i] = '0; e.trq[i] = '0;
        end
        return e;
    endfunction

    // Random pair: mostly dr inside the cutoff with a normal on its side,
    // the rest unconstrained noise.
    function automatic t_pair rand_pair();
        t_pair p;
        logic [31:0] lim;
        logic signed [33:0] dr;
        int sel;
        p = blank_pair();
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            p.node[i] = $urandom;
            p.arm[i] = ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom) >>> 12);
            if (sel < 2) begin
                p.bead[i] = $urandom;
                p.nrm[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
            end else begin
                lim = {1'b0, cut_q};
                if (sel < 6) lim = lim >> $urandom_range(1, 4);
                if (lim > 32'h7FFF_FFFE) lim = 32'h7FFF_FFFE;
                dr = 34'($urandom_range(0, lim));
                if ($urandom_range(0, 1)) dr = -dr;
                p.bead[i] = 32'(34'(p.node[i]) + dr);
                p.nrm[i] = 18'($urandom_range(0, 65536));
                if (dr < 0) p.nrm[i] = -p.nrm[i];
            end
        end
        return p;
    endfunction

    t_row rows [$];

    task automatic add_row(t_pair p, bit typed, t_res e);
        t_row r;
        r.p = p; r.typed = typed; r.e = e;
        rows.push_back(r);
    endtask

    task automatic build_rows();
        t_pair p;
        t_res e;
        // zero dr: miss
        p = blank_pair(); p.nrm[0] = 18'sd65536;
        add_row(p, 1, miss_res());
        // extremes, same bead and node: zero dr, miss
        p = blank_pair();
        for (int i = 0; i < 3; i++) begin
            p.bead[i] = 32'h7FFF_FFFF; p.node[i] = 32'h7FFF_FFFF;
            p.nrm[i] = -18'sd65536; p.arm[i] = 32'h8000_0000;
        end
        add_row(p, 1, miss_res());
        // largest spread, far outside cutoff: miss
        p = blank_pair();
        for (int i = 0; i < 3; i++) begin
            p.bead[i] = 32'h7FFF_FFFF; p.node[i] = 32'h8000_0000;
            p.nrm[i] = 18'sd65536; p.arm[i] = 32'h7FFF_FFFF;
        end
        add_row(p, 1, miss_res());
        // wrong side of the normal
        p = blank_pair(); p.bead[0] = 32'sd327680; p.nrm[0] = -18'sd65536;
        add_row(p, 1, miss_res());
        // dr exactly at cutoff: miss
        p = blank_pair(); p.bead[1] = 32'sd655360; p.nrm[1] = 18'sd65536;
        add_row(p, 1, miss_res());
        // dr = 5.0 along x, arm = 1.0 along y: force 5.0, torque_z 5.0
        p = blank_pair(); p.bead[0] = 32'sd327680; p.nrm[0] = 18'sd65536;
        p.arm[1] = 32'sd65536;
        e = miss_res(); e.hit = 1'b1; e.frc[0] = 32'sd327680; e.trq[2] = 32'sd327680;
        add_row(p, 1, e);
        // one lsb of dr: r clamps to 1 lsb, force is one lsb short of the cutoff
        p = blank_pair(); p.bead[2] = 32'sd1; p.nrm[2] = 18'sd1;
        add_row(p, 0, e);
        p = blank_pair(); p.bead[2] = -32'sd1; p.nrm[2] = -18'sd65536;
        p.arm[0] = 32'h7FFF_FFFF; p.arm[1] = 32'h8000_0000;
        add_row(p, 0, e);
        // just inside cutoff, diagonal, negative node corner
        p = blank_pair();
        for (int i = 0; i < 3; i++) begin
            p.node[i] = 32'h8000_0000; p.bead[i] = 32'h8000_0000 + 32'sd370000;
            p.nrm[i] = 18'sd37837; p.arm[i] = 32'sd65536 * (i + 1);
        end
        add_row(p, 0, e);
        // dot just above zero with mixed signs
        p = blank_pair(); p.bead[0] = 32'sd100000; p.bead[1] = -32'sd99999;
        p.nrm[0] = 18'sd65536; p.nrm[1] = 18'sd65536; p.arm[2] = 32'h8000_0000;
        add_row(p, 0, e);
        // dot exactly zero: miss
        p = blank_pair(); p.bead[0] = 32'sd100000; p.bead[1] = -32'sd100000;
        p.nrm[0] = 18'sd65536; p.nrm[1] = 18'sd65536;
        add_row(p, 1, miss_res());
        for (int k = 0; k < 8; k++) add_row(rand_pair(), 0, e);
    endtask

    task automatic run_random(int n);
        t_res e;
        e = miss_res();
        repeat (n) send_pair(rand_pair(), 0, e);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_STIFFNESS;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        put_pair(blank_pair());
        out_ch.ready = 1'b0;
        rx_left = 0;
        burst_left = 0;
        err_cnt = 0; pairs_in = 0; beats_out = 0; hits_out = 0; idle_cnt = 0;
        stiff_q = 32'd65536; cut_q = 31'd655360; mind_q = 31'd1;
        cur_pair = blank_pair(); cur_typed = 0; cur_exp = miss_res();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values: directed table, then random
        build_rows();
        foreach (rows[k]) send_pair(rows[k].p, rows[k].typed, rows[k].e);
        run_random(RAND_PER_SET);

        // widest range, strongest spring; unused index must change nothing
        drain();
        write_reg(CFG_STIFFNESS, 32'hFFFF_FFFF);
        write_reg(CFG_CUTOFF, 32'hFFFF_FFFF);      // bit 31 masked off
        write_reg(CFG_MIN_DIST, 32'd1);
        write_reg(CFG_IDX_UNUSED, 32'd12345);
        run_random(RAND_PER_SET);

        // min_distance past cutoff: force pulls toward the node
        drain();
        write_reg(CFG_STIFFNESS, 32'd200000);
        write_reg(CFG_CUTOFF, 32'd300000);
        write_reg(CFG_MIN_DIST, 32'h7FFF_FFFF);
        run_random(RAND_PER_SET);

        // zero clamp acts as one lsb, zero stiffness
        drain();
        write_reg(CFG_STIFFNESS, 32'd0);
        write_reg(CFG_MIN_DIST, 32'd0);
        run_random(RAND_PER_SET / 2);
        drain();
        write_reg(CFG_STIFFNESS, 32'd65536);
        run_random(RAND_PER_SET / 2);

        // zero cutoff: every pair misses
        drain();
        write_reg(CFG_CUTOFF, 32'd0);
        run_random(RAND_PER_SET / 2);

        // mid-range settings
        drain();
        write_reg(CFG_STIFFNESS, $urandom);
        write_reg(CFG_CUTOFF, $urandom_range(65536, 32'h0100_0000));
        write_reg(CFG_MIN_DIST, $urandom_range(1, 65536));
        run_random(RAND_PER_SET);
        drain();
        write_reg(CFG_STIFFNESS, $urandom_range(1, 32'h0010_0000));
        write_reg(CFG_CUTOFF, 32'h8000_0000 | $urandom);
        write_reg(CFG_MIN_DIST, $urandom_range(1, 32'h7FFF_FFFF));
        run_random(RAND_PER_SET);

        drain();
        $display("tb_top: %0d pairs sent, %0d result beats checked, %0d of them hits,",
                 pairs_in, beats_out, hits_out);
        $display("tb_top: eight register settings incl. range and clamp extremes");
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
